### rtl/core/dhacc_pkg.sv
// Shared types, constants and arithmetic helpers for the daily histogram accumulator.
`timescale 1ns / 1ps
`default_nettype none
package dhacc_pkg;

	// storage geometry
	localparam int MAX_DAYS    = 64;
	localparam int MAX_BINS    = 256;
	localparam int COUNT_WIDTH = 32;

	localparam int DAY_W    = $clog2(MAX_DAYS);
	localparam int DAYS_W   = $clog2(MAX_DAYS + 1);
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int WALK_W   = $clog2(MAX_BINS + 1);
	localparam int DMEM_D   = MAX_DAYS * MAX_BINS;
	localparam int DADDR_W  = $clog2(DMEM_D);

	// fixed field widths
	localparam int KIND_W    = 2;
	localparam int VALUE_W   = 24;
	localparam int RDAY_W    = 6;
	localparam int RBIN_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int LAST_W    = 8;
	localparam int SCALE_W   = 24;
	localparam int START_W   = 6;
	localparam int DCOUNT_W  = 7;
	localparam int ADAY_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;

	// Q16.8 * Q8.16 -> Q24.24
	localparam int PROD_W = VALUE_W + SCALE_W;
	localparam int FRAC_W = 24;
	localparam int RAW_W  = PROD_W - FRAC_W;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

	// stream packing
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 80;

	// reset values of the registers
	localparam logic [LAST_W-1:0]   LAST_BIN_RST  = 8'd255;
	localparam logic [SCALE_W-1:0]  BIN_SCALE_RST = 24'd65536;
	localparam logic [START_W-1:0]  START_DAY_RST = 6'd0;
	localparam logic [DCOUNT_W-1:0] DAY_COUNT_RST = 7'd64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_BIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DAY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_COUNT = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_CLAMP = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD     = 2'd0,
		KIND_REMOVE  = 2'd1,
		KIND_END_DAY = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_WALK,
		ST_DONE
	} state_t;

	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic signed [COUNT_WIDTH-1:0] CNT_NEG = {COUNT_WIDTH{1'b1}};

	// classified item handed from front to back
	typedef struct packed {
		kind_t              kind;
		logic [BIN_W-1:0]   bin;
		logic               clamp;
		logic [RDAY_W-1:0]  rday;
	} item_t;

	// one result
	typedef struct packed {
		logic [STATUS_W-1:0]          status;
		logic [BIN_W-1:0]             bin_index;
		logic signed [COUNT_WIDTH-1:0] day_tally;
		logic signed [COUNT_WIDTH-1:0] total_tally;
		logic [ADAY_W-1:0]            active_day;
	} res_t;

	// signed add that sticks at the count limits
	function automatic logic signed [COUNT_WIDTH-1:0] sat_add(
		input logic signed [COUNT_WIDTH-1:0] a,
		input logic signed [COUNT_WIDTH-1:0] b
	);
		logic signed [COUNT_WIDTH:0] s;
		s = {a[COUNT_WIDTH-1], a} + {b[COUNT_WIDTH-1], b};
		if (s[COUNT_WIDTH] != s[COUNT_WIDTH-1]) begin
			sat_add = s[COUNT_WIDTH] ? CNT_MIN : CNT_MAX;
		end else begin
			sat_add = s[COUNT_WIDTH-1:0];
		end
	endfunction

endpackage
`default_nettype wire

### rtl/core/dhacc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dhacc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/dhacc_front.sv
// Front end: takes input transfers, scales the sample and classifies the bin.
`timescale 1ns / 1ps
`default_nettype none
module dhacc_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 hold,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [dhacc_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic [dhacc_pkg::KIND_W-1:0]         s_tuser,
	input  wire logic [dhacc_pkg::BIN_W-1:0]          eff_last,
	input  wire logic [dhacc_pkg::SCALE_W-1:0]        bin_scale,
	input  wire logic                                 q_full,
	output logic                                      push,
	output dhacc_pkg::item_t                          item
);
	import dhacc_pkg::*;

	logic                vld_s1;
	kind_t               kind_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [RDAY_W-1:0]   rday_s1;
	logic [RBIN_W-1:0]   rbin_s1;

	logic [PROD_W-1:0]   rnd;
	logic [RAW_W-1:0]    cand;
	logic                take;

	assign push     = vld_s1 && !q_full;
	assign s_tready = !hold && (!vld_s1 || push);
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// multiply at the input, register the full product
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind_t'(s_tuser);
			prod_s1 <= PROD_W'(s_tdata[VALUE_W-1:0]) * PROD_W'(bin_scale);
			rday_s1 <= s_tdata[VALUE_W+RDAY_W-1:VALUE_W];
			rbin_s1 <= s_tdata[VALUE_W+RDAY_W+RBIN_W-1:VALUE_W+RDAY_W];
		end
	end

	// round half up (read items use the read bin instead), then clamp at the last bin
	always_comb begin
		rnd = prod_s1 + ROUND_HALF;
		if (kind_s1 == KIND_READ) begin
			cand = RAW_W'(rbin_s1);
		end else begin
			cand = rnd[PROD_W-1:FRAC_W];
		end
		item.kind  = kind_s1;
		item.rday  = rday_s1;
		item.clamp = cand > RAW_W'(eff_last);
		item.bin   = item.clamp ? eff_last : cand[BIN_W-1:0];
	end

endmodule
`default_nettype wire

### rtl/core/dhacc_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module dhacc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dhacc_pkg::item_t  din,
	output logic                   full,
	input  wire logic              pop,
	output dhacc_pkg::item_t       dout,
	output logic                   empty
);
	import dhacc_pkg::*;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	item_t              slot_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full  = cnt_q == CNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

### rtl/core/dhacc_back.sv
// Back end: clears the memories, runs updates, reads and the end-of-day walk.
`timescale 1ns / 1ps
`default_nettype none
module dhacc_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [dhacc_pkg::DAYS_W-1:0]      eff_days,
	input  wire logic                              load_day,
	input  wire logic [dhacc_pkg::START_W-1:0]     start_day,
	input  wire logic                              q_empty,
	input  wire dhacc_pkg::item_t                  q_item,
	output logic                                   pop,
	output logic                                   clearing,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output dhacc_pkg::res_t                        m_res
);
	import dhacc_pkg::*;

	state_t                  state_q, state_d;
	logic [DAYS_W-1:0]       day_index_q;
	logic                    day_inc;
	logic [DADDR_W-1:0]      clr_q;
	logic [WALK_W-1:0]       walk_q;
	item_t                   op_q;
	logic                    in_range_q;
	logic                    in_range_d;
	res_t                    res_q, res_d;
	logic                    load_res;
	logic                    load_out;
	logic                    out_free;

	// memory ports
	logic                    d_we, t_we;
	logic [DADDR_W-1:0]      d_waddr, d_raddr;
	logic [BIN_W-1:0]        t_waddr, t_raddr;
	logic [COUNT_WIDTH-1:0]  d_wdata, t_wdata, d_rdata, t_rdata;
	logic signed [COUNT_WIDTH-1:0] upd;

	dhacc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DMEM_D)) u_day_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	dhacc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BINS)) u_total_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	assign clearing = state_q == ST_CLEAR;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		day_inc    = 1'b0;
		load_res   = 1'b0;
		load_out   = 1'b0;
		res_d      = res_q;
		in_range_d = 1'b0;
		d_we       = 1'b0;
		t_we       = 1'b0;
		d_waddr    = {day_index_q[DAY_W-1:0], op_q.bin};
		d_wdata    = '0;
		t_waddr    = '0;
		t_wdata    = '0;
		d_raddr    = {q_item.rday, q_item.bin};
		t_raddr    = q_item.bin;
		upd        = sat_add($signed(d_rdata),
			(op_q.kind == KIND_ADD) ? CNT_ONE : CNT_NEG);

		case (state_q)
			ST_CLEAR: begin
				d_we    = 1'b1;
				d_waddr = clr_q;
				t_we    = 1'b1;
				t_waddr = clr_q[BIN_W-1:0];
				if (clr_q == DADDR_W'(DMEM_D - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_item.kind == KIND_READ) begin
					in_range_d = DAYS_W'(q_item.rday) < eff_days;
				end else begin
					in_range_d = day_index_q < eff_days;
				end
				if (q_item.kind == KIND_ADD || q_item.kind == KIND_REMOVE) begin
					d_raddr = {day_index_q[DAY_W-1:0], q_item.bin};
				end else if (q_item.kind == KIND_END_DAY) begin
					d_raddr = {day_index_q[DAY_W-1:0], BIN_W'(0)};
					t_raddr = '0;
				end
				if (!q_empty) begin
					pop = 1'b1;
					if (q_item.kind != KIND_END_DAY) begin
						state_d = ST_ACCESS;
					end else if (in_range_d) begin
						state_d = ST_WALK;
					end else begin
						// day past the last one: nothing moves
						res_d    = '{STAT_RANGE, '0, '0, '0, '0};
						load_res = 1'b1;
						state_d  = ST_DONE;
					end
				end
			end
			ST_ACCESS: begin
				res_d.bin_index   = op_q.bin;
				res_d.total_tally = $signed(t_rdata);
				res_d.active_day  = ADAY_W'(day_index_q);
				if (!in_range_q) begin
					res_d.status    = STAT_RANGE;
					res_d.day_tally = '0;
				end else begin
					res_d.status = op_q.clamp ? STAT_CLAMP : STAT_OK;
					if (op_q.kind == KIND_READ) begin
						res_d.day_tally = $signed(d_rdata);
					end else begin
						res_d.day_tally = upd;
						d_we            = 1'b1;
						d_wdata         = upd;
					end
				end
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					load_res = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_WALK: begin
				// read bin walk_q while writing back bin walk_q-1
				d_raddr = {day_index_q[DAY_W-1:0], walk_q[BIN_W-1:0]};
				t_raddr = walk_q[BIN_W-1:0];
				t_waddr = BIN_W'(walk_q - WALK_W'(1));
				t_wdata = sat_add($signed(t_rdata), $signed(d_rdata));
				t_we    = walk_q != '0;
				if (walk_q == WALK_W'(MAX_BINS)) begin
					day_inc  = 1'b1;
					res_d    = '{STAT_OK, '0, '0, '0, '0};
					load_res = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_d.active_day = ADAY_W'(day_index_q);
					load_out         = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			day_index_q <= DAYS_W'(START_DAY_RST);
			clr_q       <= '0;
			walk_q      <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_day) begin
				day_index_q <= DAYS_W'(start_day);
			end else if (day_inc) begin
				day_index_q <= day_index_q + DAYS_W'(1);
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + DADDR_W'(1);
			end
			if (state_q == ST_WALK) begin
				walk_q <= walk_q + WALK_W'(1);
			end else begin
				walk_q <= WALK_W'(1);
			end
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q       <= q_item;
			in_range_q <= in_range_d;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (load_out) begin
			m_res <= res_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/daily_histogram_accumulator.sv
// Top level of the daily histogram accumulator: config registers, front, queue and back.
//
// Keeps a MAX_DAYS x MAX_BINS histogram of signed saturating counts plus one total
// histogram. After reset the block first sweeps both memories to zero, one entry per
// cycle over MAX_DAYS*MAX_BINS = 16384 entries; s_tready stays low during that sweep
// while config writes are still taken. Each input transfer is registered in the front
// (sample times bin_scale into a product register), then waits in a two-entry queue.
// The back end takes add, remove and read items one at a time (memory read, then
// modify and write back) and pops no new item until the last one is done. End of day
// walks every bin with the day and total memory ports, read of bin k alongside
// write-back of bin k-1. Results sit in an output register; while the consumer stalls
// with that register full, the back end parks its next result in a holding register and waits.
`timescale 1ns / 1ps
`default_nettype none
module daily_histogram_accumulator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// config write port
	input  wire logic                                 cfg_we,
	input  wire logic [dhacc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dhacc_pkg::CFG_W-1:0]          cfg_data,
	// input stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [dhacc_pkg::IN_TDATA_W-1:0]     s_tdata,  // value[23:0], read_day[29:24], read_bin[37:30], zero pad
	input  wire logic [dhacc_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
	// result stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [dhacc_pkg::OUT_TDATA_W-1:0]         m_tdata,  // bin_index[7:0], day_tally[39:8], total_tally[71:40], active_day[78:72], zero pad
	output logic [dhacc_pkg::STATUS_W-1:0]            m_tuser   // status[1:0]
);
	import dhacc_pkg::*;

	logic [LAST_W-1:0]    last_bin_q;
	logic [SCALE_W-1:0]   bin_scale_q;
	logic [DCOUNT_W-1:0]  day_count_q;
	logic [BIN_W-1:0]     eff_last;
	logic [DAYS_W-1:0]    eff_days;
	logic                 load_day;

	logic                 push, pop, q_full, q_empty, clearing;
	item_t                f_item, q_item;
	res_t                 res;

	// config registers; start_day lives only as the day pointer in the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_bin_q  <= LAST_BIN_RST;
			bin_scale_q <= BIN_SCALE_RST;
			day_count_q <= DAY_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAST_BIN:  last_bin_q  <= cfg_data[LAST_W-1:0];
				CFG_BIN_SCALE: bin_scale_q <= cfg_data[SCALE_W-1:0];
				CFG_DAY_COUNT: day_count_q <= cfg_data[DCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign load_day = cfg_we && (cfg_index == CFG_START_DAY);

	// effective limits: last bin capped by the storage, days capped likewise
	assign eff_last = (32'(last_bin_q) > 32'(MAX_BINS - 1)) ?
		BIN_W'(MAX_BINS - 1) : BIN_W'(last_bin_q);
	assign eff_days = (32'(day_count_q) > 32'(MAX_DAYS)) ?
		DAYS_W'(MAX_DAYS) : DAYS_W'(day_count_q);

	dhacc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (clearing),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.eff_last  (eff_last),
		.bin_scale (bin_scale_q),
		.q_full    (q_full),
		.push      (push),
		.item      (f_item)
	);

	dhacc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_item),
		.empty  (q_empty)
	);

	dhacc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_days  (eff_days),
		.load_day  (load_day),
		.start_day (cfg_data[START_W-1:0]),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.pop       (pop),
		.clearing  (clearing),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (res)
	);

	// pack the result
	assign m_tuser = res.status;
	assign m_tdata = {1'b0, res.active_day, res.total_tally, res.day_tally, res.bin_index};

endmodule
`default_nettype wire

### rtl/core/dhacc_chk.sv
// Port-level checker for the daily histogram accumulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dhacc_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 s_tvalid,
	input wire logic                                 s_tready,
	input wire logic                                 m_tvalid,
	input wire logic                                 m_tready,
	input wire logic [dhacc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input wire logic [dhacc_pkg::STATUS_W-1:0]       m_tuser
);
	import dhacc_pkg::*;

	// items in flight: front stage, two queue slots, back end, output register
	localparam int MAX_INFLIGHT = 5;
	localparam int INF_W = $clog2(MAX_INFLIGHT + 2);

	logic [INF_W-1:0] inflight_q;
	logic             in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + INF_W'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - INF_W'(1);
		end
	end

	// no result without an item behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != '0)
		else $error("result offered with no item outstanding");

	// the pipeline never holds more than it has room for
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INF_W'(MAX_INFLIGHT))
		else $error("more items in flight than storage allows");

	// an ignored item reports no day count
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_RANGE |-> m_tdata[39:8] == 32'd0)
		else $error("out-of-range status with nonzero day tally");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind daily_histogram_accumulator dhacc_chk u_dhacc_chk (.*);
`default_nettype wire
